// ===== hw/rtl/voxel_brick_face_mask_unit_assert.svh =====
// Assertion macros for the voxel brick face mask unit.
// Depends on clk and rst_n being visible where a macro is used.
`ifndef VOXEL_BRICK_FACE_MASK_UNIT_ASSERT_SVH
`define VOXEL_BRICK_FACE_MASK_UNIT_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define VBFM_ASSERT_SAME(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define VBFM_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error(msg);

`endif

// ===== hw/rtl/vbfm_pkg.sv =====
// Package for the voxel brick face mask unit: masks, slice codes and result types.
// No dependencies.
package vbfm_pkg;

  localparam logic [63:0] COL_LOW  = 64'h0101_0101_0101_0101;
  localparam logic [63:0] COL_HIGH = 64'h8080_8080_8080_8080;
  localparam logic [63:0] ROW_LOW  = 64'h0000_0000_0000_00FF;
  localparam logic [63:0] ROW_HIGH = 64'hFF00_0000_0000_0000;
  localparam int unsigned ROW_SHIFT = 56;
  localparam int unsigned COL_SHIFT = 7;

  localparam logic [2:0] FIRST_SLICE = 3'd0;
  localparam logic [2:0] LAST_SLICE  = 3'd7;

  localparam int unsigned VBFM_FIFO_DEPTH = 4;

  typedef logic [1:0] push_cnt_t;
  localparam push_cnt_t PUSH_NONE = 2'd0;
  localparam push_cnt_t PUSH_ONE  = 2'd1;
  localparam push_cnt_t PUSH_TWO  = 2'd2;

  typedef struct packed {
    logic [63:0] nx;
    logic [63:0] px;
    logic [63:0] ny;
    logic [63:0] py;
  } side_faces_t;

  typedef struct packed {
    logic [2:0]  slice_index;
    side_faces_t sides;
    logic [63:0] neg_z;
    logic [63:0] pos_z;
    logic        last_slice;
  } face_result_t;

  typedef struct packed {
    logic [2:0]  slice;
    logic [63:0] prev_occ;
    logic [63:0] below_occ;
    side_faces_t pending;
  } brick_state_t;

endpackage

// ===== hw/rtl/vbfm_face_logic.sv =====
// Combinational face masks for one slice transaction: side faces of the current
// slice and the two possible results. Depends on vbfm_pkg.
module vbfm_face_logic import vbfm_pkg::*; (
  input  logic [63:0]  occ,
  input  logic [63:0]  nx_halo,
  input  logic [63:0]  px_halo,
  input  logic [63:0]  ny_halo,
  input  logic [63:0]  py_halo,
  input  logic [63:0]  z_halo,
  input  brick_state_t st,
  output side_faces_t  cur_sides,
  output face_result_t res_prev,
  output face_result_t res_last,
  output push_cnt_t    push_need
);

  logic [63:0] s_nx, s_px, s_ny, s_py;

  always_comb begin
    s_nx = ((occ & ~COL_HIGH) << 1) | ((nx_halo & COL_HIGH) >> COL_SHIFT);
    s_px = ((occ & ~COL_LOW) >> 1) | ((px_halo & COL_LOW) << COL_SHIFT);
    s_ny = (occ << 8) | ((ny_halo & ROW_HIGH) >> ROW_SHIFT);
    s_py = (occ >> 8) | ((py_halo & ROW_LOW) << ROW_SHIFT);

    cur_sides.nx = occ & ~s_nx;
    cur_sides.px = occ & ~s_px;
    cur_sides.ny = occ & ~s_ny;
    cur_sides.py = occ & ~s_py;

    res_prev.slice_index = st.slice - 3'd1;
    res_prev.sides       = st.pending;
    res_prev.neg_z       = st.prev_occ & ~st.below_occ;
    res_prev.pos_z       = st.prev_occ & ~occ;
    res_prev.last_slice  = 1'b0;

    res_last.slice_index = LAST_SLICE;
    res_last.sides       = cur_sides;
    res_last.neg_z       = occ & ~st.prev_occ;
    res_last.pos_z       = occ & ~z_halo;
    res_last.last_slice  = 1'b1;

    case (st.slice)
      FIRST_SLICE: push_need = PUSH_NONE;
      LAST_SLICE:  push_need = PUSH_TWO;
      default:     push_need = PUSH_ONE;
    endcase
  end

endmodule

// ===== hw/rtl/vbfm_result_fifo.sv =====
// Result queue: takes up to two results per cycle, hands one out per transaction.
// Depends on vbfm_pkg.
module vbfm_result_fifo import vbfm_pkg::*; #(
  parameter int unsigned DEPTH = VBFM_FIFO_DEPTH,
  parameter int unsigned CNT_W = $clog2(DEPTH + 1)
) (
  input  logic               clk,
  input  logic               rst_n,
  input  push_cnt_t          push_cnt,
  input  face_result_t       push_d0,
  input  face_result_t       push_d1,
  output logic               out_valid,
  input  logic               out_ready,
  output face_result_t       out_d,
  output logic [CNT_W-1:0]   fill
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  face_result_t     q_mem [DEPTH];
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt, wr_ptr_p1;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             pop;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    if (p == PTR_W'(DEPTH - 1)) begin
      return '0;
    end
    return p + PTR_W'(1);
  endfunction

  assign out_valid = (count_r != '0);
  assign out_d     = q_mem[rd_ptr_r];
  assign fill      = count_r;
  assign pop       = out_valid && out_ready;

  always_comb begin
    wr_ptr_p1  = ptr_inc(wr_ptr_r);
    rd_ptr_nxt = pop ? ptr_inc(rd_ptr_r) : rd_ptr_r;
    case (push_cnt)
      PUSH_ONE: wr_ptr_nxt = wr_ptr_p1;
      PUSH_TWO: wr_ptr_nxt = ptr_inc(wr_ptr_p1);
      default:  wr_ptr_nxt = wr_ptr_r;
    endcase
    count_nxt = count_r + CNT_W'(push_cnt) - CNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_ptr_r <= '0;
      wr_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      rd_ptr_r <= rd_ptr_nxt;
      wr_ptr_r <= wr_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push_cnt != PUSH_NONE) begin
      q_mem[wr_ptr_r] <= push_d0;
    end
    if (push_cnt == PUSH_TWO) begin
      q_mem[wr_ptr_p1] <= push_d1;
    end
  end

endmodule

// ===== hw/rtl/voxel_brick_face_mask_unit.sv =====
// Top level of the voxel brick face mask unit: brick state, face logic, result queue.
// Depends on vbfm_pkg, vbfm_face_logic, vbfm_result_fifo and the assertion header.
//
// Takes an 8x8x8 brick one z slice per transaction and returns six exposed-face
// masks per slice. One slice is accepted every cycle while in_ready is high.
// Results trail by one slice: slice 0 gives none, slices 1 to 6 give the masks of
// the slice before, and slice 7 gives two (slice 6, then slice 7 with last_slice
// set). The two-result slice is absorbed by a result queue of FIFO_DEPTH entries,
// so with the sink ready a brick streams at one slice per cycle; in_ready drops
// only when the queue lacks room for the results the next slice will produce.
`include "voxel_brick_face_mask_unit_assert.svh"

module voxel_brick_face_mask_unit import vbfm_pkg::*; #(
  parameter int unsigned FIFO_DEPTH = VBFM_FIFO_DEPTH
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [63:0] in_occupied_slice,
  input  logic [63:0] in_neg_x_halo_slice,
  input  logic [63:0] in_pos_x_halo_slice,
  input  logic [63:0] in_neg_y_halo_slice,
  input  logic [63:0] in_pos_y_halo_slice,
  input  logic [63:0] in_z_halo_slice,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  out_slice_index,
  output logic [63:0] out_neg_x_faces,
  output logic [63:0] out_pos_x_faces,
  output logic [63:0] out_neg_y_faces,
  output logic [63:0] out_pos_y_faces,
  output logic [63:0] out_neg_z_faces,
  output logic [63:0] out_pos_z_faces,
  output logic        out_last_slice
);

  localparam int unsigned CNT_W = $clog2(FIFO_DEPTH + 1);

  brick_state_t     st_r, st_nxt;
  side_faces_t      cur_sides;
  face_result_t     res_prev, res_last, out_res;
  push_cnt_t        push_need, push_cnt;
  logic [CNT_W-1:0] q_fill, q_free, q_pop_ext;
  logic             in_acc;

  vbfm_face_logic u_face (
    .occ       (in_occupied_slice),
    .nx_halo   (in_neg_x_halo_slice),
    .px_halo   (in_pos_x_halo_slice),
    .ny_halo   (in_neg_y_halo_slice),
    .py_halo   (in_pos_y_halo_slice),
    .z_halo    (in_z_halo_slice),
    .st        (st_r),
    .cur_sides (cur_sides),
    .res_prev  (res_prev),
    .res_last  (res_last),
    .push_need (push_need)
  );

  vbfm_result_fifo #(
    .DEPTH (FIFO_DEPTH),
    .CNT_W (CNT_W)
  ) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push_cnt  (push_cnt),
    .push_d0   (res_prev),
    .push_d1   (res_last),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_d     (out_res),
    .fill      (q_fill)
  );

  assign q_free    = CNT_W'(FIFO_DEPTH) - q_fill;
  assign in_ready  = rst_n && (q_free >= CNT_W'(push_need));
  assign in_acc    = in_valid && in_ready;
  assign push_cnt  = in_acc ? push_need : PUSH_NONE;
  assign q_pop_ext = CNT_W'(out_valid && out_ready);

  assign out_slice_index = out_res.slice_index;
  assign out_neg_x_faces = out_res.sides.nx;
  assign out_pos_x_faces = out_res.sides.px;
  assign out_neg_y_faces = out_res.sides.ny;
  assign out_pos_y_faces = out_res.sides.py;
  assign out_neg_z_faces = out_res.neg_z;
  assign out_pos_z_faces = out_res.pos_z;
  assign out_last_slice  = out_res.last_slice;

  always_comb begin
    st_nxt = st_r;
    if (in_acc) begin
      st_nxt.slice     = st_r.slice + 3'd1;
      st_nxt.prev_occ  = in_occupied_slice;
      st_nxt.pending   = cur_sides;
      st_nxt.below_occ = (st_r.slice == FIRST_SLICE) ? in_z_halo_slice : st_r.prev_occ;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= '0;
    end else begin
      st_r <= st_nxt;
    end
  end

  `VBFM_ASSERT_SAME(a_fill_bound, 1'b1, q_fill <= CNT_W'(FIFO_DEPTH), "result queue overfilled")
  `VBFM_ASSERT_SAME(a_last_idx, out_valid && out_last_slice, out_slice_index == LAST_SLICE, "last_slice on wrong slice")
  `VBFM_ASSERT_NEXT(a_slice_adv, rst_n && in_valid && in_ready, st_r.slice == $past(st_r.slice) + 3'd1, "slice counter did not advance")
  `VBFM_ASSERT_NEXT(a_first_quiet, rst_n && in_valid && in_ready && st_r.slice == FIRST_SLICE, q_fill == $past(q_fill) - $past(q_pop_ext), "first slice pushed a result")

endmodule
